### rtl/fxh32_pkg.sv
package fxh32_pkg;

  // Multiplier key and rotate distance of one mix step
  localparam logic [31:0] FX_KEY = 32'h27220a95;
  localparam int unsigned FX_ROT = 5;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic absorb;    // take one message byte
    logic mix_tail;  // mix the next leftover tail byte
    logic emit;      // load the digest and clear the hash state
  } fxh32_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic tail_done; // every leftover byte has been mixed in
  } fxh32_sts_t;

endpackage

### rtl/fxh32_dp.sv
module fxh32_dp
  import fxh32_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  fxh32_cmd_t  cmd,
  input  logic [7:0]  data_byte,
  output fxh32_sts_t  sts,
  output logic [31:0] digest
);

  logic [31:0] hash_r, hash_nxt;
  logic [23:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] digest_r;

  logic [31:0] rot;
  logic [31:0] mix_val;
  logic [31:0] mix_res;
  logic [7:0]  tail_byte;

  // Tail byte selected by the tail index
  always_comb begin
    case (idx_r)
      2'd0:    tail_byte = pend_r[7:0];
      2'd1:    tail_byte = pend_r[15:8];
      2'd2:    tail_byte = pend_r[23:16];
      default: tail_byte = 8'h00;
    endcase
  end

  // Shared mix unit: rotate, xor, multiply by key (low 32 bits)
  assign rot     = {hash_r[31-FX_ROT:0], hash_r[31:32-FX_ROT]};
  assign mix_val = cmd.mix_tail ? {24'h000000, tail_byte} : {data_byte, pend_r};
  assign mix_res = (rot ^ mix_val) * FX_KEY;

  // Next-state of hash, pending bytes and tail index
  always_comb begin
    hash_nxt = hash_r;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    if (cmd.emit) begin
      hash_nxt = '0;
      pend_nxt = '0;
      cnt_nxt  = '0;
      idx_nxt  = '0;
    end else if (cmd.mix_tail) begin
      hash_nxt = mix_res;
      idx_nxt  = idx_r + 2'd1;
    end else if (cmd.absorb) begin
      case (cnt_r)
        2'd0: begin
          pend_nxt[7:0] = data_byte;
          cnt_nxt       = 2'd1;
        end
        2'd1: begin
          pend_nxt[15:8] = data_byte;
          cnt_nxt        = 2'd2;
        end
        2'd2: begin
          pend_nxt[23:16] = data_byte;
          cnt_nxt         = 2'd3;
        end
        default: begin
          // full word: mix it in and start a new one
          hash_nxt = mix_res;
          pend_nxt = '0;
          cnt_nxt  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
      pend_r <= '0;
      cnt_r  <= '0;
      idx_r  <= '0;
    end else begin
      hash_r <= hash_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Digest register, loaded on emit
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digest_r <= hash_r;
    end
  end

  assign sts.tail_done = (idx_r == cnt_r);
  assign digest        = digest_r;

endmodule

### rtl/fxh32_ctrl.sv
module fxh32_ctrl
  import fxh32_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_final,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  fxh32_sts_t sts,
  output fxh32_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TAIL = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  // Output slot can take a digest when empty or being drained
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.absorb   = 1'b0;
    cmd.mix_tail = 1'b0;
    cmd.emit     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.absorb = in_valid;
        if (in_valid && in_final) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL: begin
        if (!sts.tail_done) begin
          cmd.mix_tail = 1'b1;
        end else if (slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/fxhash32_byte_stream_core.sv
// Channel | Ports                                   | Direction
// input   | in_valid, in_ready, in_data_byte,        | in (ready out)
//         | in_final_byte                            |
// result  | out_valid, out_ready, out_digest         | out (ready in)
//
// An ordinary byte is taken whenever the core is idle: it is buffered, or
// completes a word that the single mix unit (rotate, xor, 32x32 multiply)
// folds in the same cycle. A final byte is accepted, then the tail state mixes
// in the n = 0..3 leftover tail bytes singly, then loads the output register.
// The digest waits in an output register; new bytes are taken meanwhile, and
// only the next final byte holds in its tail state until that register frees.
// Synchronous active-low reset clears the hash, the byte buffer and control.
module fxhash32_byte_stream_core
  import fxh32_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest
);

  fxh32_cmd_t cmd;
  fxh32_sts_t sts;

  fxh32_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_final  (in_final_byte),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fxh32_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_data_byte),
    .sts       (sts),
    .digest    (out_digest)
  );

endmodule

### tb/fxhash32_checker.sv
`timescale 1ns / 100ps

module fxhash32_checker
  import fxh32_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_final_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest,
  output int          fail_count,
  output int          digests_owed
);

  // Shadow copy of the hashing state
  logic [31:0] run_hash;
  logic [23:0] tail_bytes;
  logic [1:0]  tail_cnt;
  logic [31:0] digest_q[$];
  logic [31:0] exp_digest;

  // One mix step: rotate left, xor the value, multiply by the key mod 2^32
  function automatic logic [31:0] mix_step(logic [31:0] h, logic [31:0] v);
    logic [31:0] r;
    r = {h[26:0], h[31:27]};
    return (r ^ v) * FX_KEY;
  endfunction

  // Fold one accepted byte into the shadow state; a final byte queues a digest
  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    logic [31:0] h;
    logic [23:0] held;
    logic [1:0]  cnt;
    h    = run_hash;
    held = tail_bytes;
    cnt  = tail_cnt;
    if (cnt == 2'd3) begin
      // fourth byte completes a little-endian word
      h    = mix_step(h, {b, held});
      held = '0;
      cnt  = '0;
    end else begin
      held[8*cnt +: 8] = b;
      cnt = cnt + 2'd1;
    end
    if (fin) begin
      // leftover tail bytes go in one at a time, zero-extended
      for (int i = 0; i < cnt; i++) begin
        h = mix_step(h, {24'd0, held[8*i +: 8]});
      end
      digest_q.push_back(h);
      run_hash   = '0;
      tail_bytes = '0;
      tail_cnt   = '0;
    end else begin
      run_hash   = h;
      tail_bytes = held;
      tail_cnt   = cnt;
    end
  endtask

  // Track requests on both channels and compare each digest in order
  always @(posedge clk) begin
    if (!rst_n) begin
      run_hash   = '0;
      tail_bytes = '0;
      tail_cnt   = '0;
      digest_q.delete();
      fail_count = 0;
      digests_owed <= 0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_byte(in_data_byte, in_final_byte);
      end
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $error("out_digest: expected none, got %08h", out_digest);
          fail_count++;
        end else begin
          exp_digest = digest_q.pop_front();
          if (out_digest !== exp_digest) begin
            $error("out_digest: expected %08h, got %08h", exp_digest, out_digest);
            fail_count++;
          end
        end
      end
      digests_owed <= digest_q.size();
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fxh32_pkg::*;

  localparam int ITEM_TARGET = 1650;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_final_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest;

  int fail_count;
  int digests_owed;
  int bytes_sent;
  int holds_asked;
  int holds_done;
  bit no_idle;

  fxhash32_byte_stream_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digest    (out_digest)
  );

  fxhash32_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digest    (out_digest),
    .fail_count    (fail_count),
    .digests_owed  (digests_owed)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Mostly back-to-back, often short gaps, now and then a long one
  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Message length: mostly short, some medium, a few long
  function automatic int pick_len();
    int p;
    p = $urandom_range(99);
    if (p < 70) return $urandom_range(1, 8);
    if (p < 92) return $urandom_range(9, 24);
    return $urandom_range(25, 64);
  endfunction

  // Offer one byte and hold it until the request is taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid for an idle gap given by n, with junk on the payload
  task automatic idle_for(input int n);
    if (n > 0) begin
      in_valid      <= 1'b0;
      in_data_byte  <= 8'($urandom);
      in_final_byte <= 1'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // Send a message: bytes from v (lowest first) or random ones
  task automatic send_msg(input logic [63:0] v, input int len, input bit rnd);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = rnd ? 8'($urandom) : v[8*i +: 8];
      send_byte(b, i == len - 1);
      // no gaps while the receiver is held off, so the block backs up
      if (!no_idle && holds_done == holds_asked) idle_for(pick_gap());
    end
  endtask

  // Stop sending until every digest has come back
  task automatic drain_wait();
    idle_for(1);
    wait (digests_owed == 0);
    @(posedge clk);
  endtask

  // Receiver side: random ready, with long hold-offs on demand
  initial begin : rx_side
    int gap;
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (holds_done < holds_asked) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin : tx_side
    int msg_idx;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_final_byte = 1'b0;
    bytes_sent    = 0;
    holds_asked   = 0;
    holds_done    = 0;
    no_idle       = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single bytes at both extremes, every tail length,
    // a word completed on the final byte, and word plus tail
    send_msg(64'h00, 1, 1'b0);
    send_msg(64'hff, 1, 1'b0);
    send_msg(64'h8001, 2, 1'b0);
    send_msg(64'hff55aa, 3, 1'b0);
    send_msg(64'hffffffff, 4, 1'b0);
    send_msg(64'h01_00000000, 5, 1'b0);
    send_msg(64'hf00f5aa5_3cc37f80, 8, 1'b0);
    drain_wait();

    // Random messages
    msg_idx = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (msg_idx == 30) holds_asked++;
      if (msg_idx == 90) drain_wait();
      no_idle = ($urandom_range(99) < 30);
      send_msg(64'd0, pick_len(), 1'b1);
      msg_idx++;
    end

    // Let everything drain, then a short tail for stray digests
    idle_for(1);
    wait (digests_owed == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
rtl/fxh32_pkg.sv
rtl/fxh32_dp.sv
rtl/fxh32_ctrl.sv
rtl/fxhash32_byte_stream_core.sv
tb/fxhash32_checker.sv
tb/tb_top.sv
